### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: field widths, entry
// and result layouts, error codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int PRIO_W     = 8;
    localparam int TAG_W      = 16;
    localparam int CNT_W      = 5;
    localparam int ERR_W      = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // Operation codes carried in tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    // One queue slot, priority in the low bits
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // Result word, head priority in the low bits
    typedef struct packed {
        t_err              err;
        logic [CNT_W-1:0]  count;
        logic              empty;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } t_out_data;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_PLACE,
        ST_POP,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_CAPTURE,
        DP_PUSH_START,
        DP_WALK_SHIFT,
        DP_PLACE,
        DP_POP_START,
        DP_POP_SHIFT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   occ_dec;
        logic   load_out;
        t_err   err;
    } t_dp_cmd;

    typedef struct packed {
        logic item_pop;
        logic occ_zero;
        logic occ_one;
        logic occ_full;
        logic rd_gt;
        logic ptr_last;
        logic pop_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer of the sorted priority queue: decodes one operation, steps the
// datapath through the slot walk and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire spq_pkg::t_dp_status i_status,
    output spq_pkg::t_dp_cmd        o_cmd
);
    import spq_pkg::*;

    t_state r_state, n_state;
    t_err   r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_err   <= ERR_NONE;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_err   = r_err;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_err   = ERR_NONE;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!i_status.item_pop) begin
                    if (i_status.occ_full) begin
                        n_err   = ERR_FULL;
                        n_state = ST_DONE;
                    end else if (i_status.occ_zero) begin
                        n_state = ST_PLACE;
                    end else begin
                        n_state = ST_WALK;
                    end
                end else begin
                    if (i_status.occ_zero) begin
                        n_err   = ERR_EMPTY;
                        n_state = ST_DONE;
                    end else if (i_status.occ_one) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_POP;
                    end
                end
            end
            ST_WALK: begin
                if (!i_status.rd_gt || i_status.ptr_last) begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE: begin
                n_state = ST_DONE;
            end
            ST_POP: begin
                if (i_status.pop_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.op       = DP_NONE;
        o_cmd.occ_dec  = 1'b0;
        o_cmd.load_out = 1'b0;
        o_cmd.err      = r_err;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_CAPTURE;
                end
            end
            ST_DECODE: begin
                if (!i_status.item_pop) begin
                    if (!i_status.occ_full) begin
                        o_cmd.op = DP_PUSH_START;
                    end
                end else if (!i_status.occ_zero) begin
                    if (i_status.occ_one) begin
                        o_cmd.occ_dec = 1'b1;
                    end else begin
                        o_cmd.op = DP_POP_START;
                    end
                end
            end
            ST_WALK: begin
                if (i_status.rd_gt) begin
                    o_cmd.op = DP_WALK_SHIFT;
                end
            end
            ST_PLACE: begin
                o_cmd.op = DP_PLACE;
            end
            ST_POP: begin
                o_cmd.op      = DP_POP_SHIFT;
                o_cmd.occ_dec = i_status.pop_last;
            end
            ST_DONE: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_cmd.op = DP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Slot memory, walk pointer, occupancy, head shadow and output register of
// the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_op,
    input  wire logic [spq_pkg::IN_DATA_W-1:0]     i_data,
    input  wire spq_pkg::t_dp_cmd                  i_cmd,
    output spq_pkg::t_dp_status                    o_status,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [spq_pkg::OUT_DATA_W-1:0]         o_out_data
);
    import spq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_entry          mem [QUEUE_DEPTH];
    t_entry          r_rdata;
    t_entry          r_item;
    t_entry          r_head;
    logic            r_op;
    logic [CW-1:0]   r_ptr;
    logic [CW-1:0]   r_occ;
    logic            r_out_valid;
    t_out_data       r_out_data;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    t_entry          wdata;
    logic [CW-1:0]   occ_m1;
    logic [CW-1:0]   ptr_m1;
    logic [CW-1:0]   ptr_m2;
    logic [CW-1:0]   ptr_p1;
    logic            out_free;

    assign occ_m1   = r_occ - CW'(1);
    assign ptr_m1   = r_ptr - CW'(1);
    assign ptr_m2   = r_ptr - CW'(2);
    assign ptr_p1   = r_ptr + CW'(1);
    assign out_free = !r_out_valid || i_out_ready;

    // Memory port selection
    always_comb begin
        we    = 1'b0;
        waddr = r_ptr[AW-1:0];
        wdata = r_rdata;
        raddr = '0;
        case (i_cmd.op)
            DP_PUSH_START: begin
                raddr = occ_m1[AW-1:0];
            end
            DP_WALK_SHIFT: begin
                we    = 1'b1;
                raddr = ptr_m2[AW-1:0];
            end
            DP_PLACE: begin
                we    = 1'b1;
                wdata = r_item;
            end
            DP_POP_START: begin
                raddr = AW'(1);
            end
            DP_POP_SHIFT: begin
                we    = 1'b1;
                waddr = ptr_m1[AW-1:0];
                raddr = ptr_p1[AW-1:0];
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    // Item, head shadow and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_CAPTURE) begin
            r_op   <= i_op;
            r_item <= t_entry'(i_data);
        end
        if (we && (waddr == '0)) begin
            r_head <= wdata;
        end
        if (i_cmd.load_out) begin
            r_out_data.err   <= i_cmd.err;
            r_out_data.count <= CNT_W'(r_occ);
            r_out_data.empty <= (r_occ == '0);
            r_out_data.tag   <= (r_occ == '0) ? '0 : r_head.tag;
            r_out_data.prio  <= (r_occ == '0) ? '0 : r_head.prio;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                DP_PUSH_START: r_ptr <= r_occ;
                DP_WALK_SHIFT: r_ptr <= ptr_m1;
                DP_POP_START:  r_ptr <= CW'(1);
                DP_POP_SHIFT:  r_ptr <= ptr_p1;
                default:       r_ptr <= r_ptr;
            endcase
            if (i_cmd.op == DP_PLACE) begin
                r_occ <= r_occ + CW'(1);
            end else if (i_cmd.occ_dec) begin
                r_occ <= occ_m1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.item_pop = (r_op == OP_POP);
    assign o_status.occ_zero = (r_occ == '0);
    assign o_status.occ_one  = (r_occ == CW'(1));
    assign o_status.occ_full = (r_occ >= CW'(QUEUE_DEPTH));
    assign o_status.rd_gt    = (r_rdata.prio > r_item.prio);
    assign o_status.ptr_last = (r_ptr == CW'(1));
    assign o_status.pop_last = (ptr_p1 == r_occ);
    assign o_status.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_DATA_W'(r_out_data);

endmodule

`default_nettype wire

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-first priority queue of process handles, ties served in order
// of arrival, with one status result per push or pop.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH entries sorted by ascending priority in a
// one-write, one-read slot memory, slot 0 being the head. It takes one
// operation at a time. A push walks down from the top slot, one slot per
// cycle, moving each entry of strictly greater priority up by one and then
// placing the new entry; the input is ready again in the cycle in which the
// result is first offered. A pop shifts the remaining entries down one slot
// per cycle. Pops of an empty queue and pushes into a full one change nothing
// and come back with an error code. The result sits in an output register,
// so a new operation is accepted while the previous result still waits; the
// queue only holds its next result until the output side takes the old one.
// Slot contents need no clearing after reset: only slots below the count
// ever reach a result.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] priority_req, [23:8] process_tag
    input  wire logic [spq_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [0] op (0 push, 1 pop)
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [7:0] head_priority, [23:8] head_tag, [24] is_empty,
    // [29:25] entry_count, [31:30] error_code
    output logic [spq_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import spq_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequence each operation
    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Hold the slots, the count and the result
    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [spq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import spq_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One operation at a time: busy right after a transfer in
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // An empty queue reports zero head fields
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[23:0] == '0)
        else $error("empty result with nonzero head");

    // A pop of an empty queue reports empty
    a_empty_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[31:30] == ERR_EMPTY |-> m_axis_tdata[24])
        else $error("empty-pop error on a nonempty queue");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire

### sim/queue_check_pkg.sv
// ----------------------------------------------------------------------------
// queue_check_pkg
// Scoreboard for the sorted priority queue: keeps a sorted copy of the queue,
// works out the status word each operation must produce and compares the
// status words that come out of the block against it in order.
// ----------------------------------------------------------------------------

package queue_check_pkg;

    import spq_pkg::*;

    class queue_scoreboard;

        int        depth;
        int        mismatches;
        // Queue copy, head at index 0, ascending priority, ties in arrival order
        t_entry    held_entries[$];
        // Status words still owed by the block, oldest first
        t_out_data owed_status[$];

        function new(int queue_depth);
            depth      = queue_depth;
            mismatches = 0;
        endfunction

        // Apply one accepted push or pop and queue the status it must report.
        function void note_operation(logic op, t_entry item);
            t_out_data status;
            int        pos;
            status = '0;
            status.err = ERR_NONE;
            if (op == OP_PUSH) begin
                if (held_entries.size() >= depth) begin
                    status.err = ERR_FULL;
                end else begin
                    // Go behind every entry of lower or equal priority
                    pos = 0;
                    while (pos < held_entries.size() && held_entries[pos].prio <= item.prio)
                        pos++;
                    held_entries.insert(pos, item);
                end
            end else begin
                if (held_entries.size() == 0)
                    status.err = ERR_EMPTY;
                else
                    void'(held_entries.pop_front());
            end
            status.empty = (held_entries.size() == 0);
            if (!status.empty) begin
                status.prio = held_entries[0].prio;
                status.tag  = held_entries[0].tag;
            end
            status.count = CNT_W'(held_entries.size());
            owed_status.push_back(status);
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                mismatches++;
            end
        endfunction

        // Compare one status transfer against the oldest owed status.
        function void check_status(logic [OUT_DATA_W-1:0] word);
            t_out_data got;
            t_out_data want;
            got = t_out_data'(word);
            if (owed_status.size() == 0) begin
                $error("status transfer with no operation outstanding: %h", word);
                mismatches++;
                return;
            end
            want = owed_status.pop_front();
            compare_field("head_priority", want.prio,  got.prio);
            compare_field("head_tag",      want.tag,   got.tag);
            compare_field("is_empty",      want.empty, got.empty);
            compare_field("entry_count",   want.count, got.count);
            compare_field("error_code",    want.err,   got.err);
        endfunction

        function int outstanding();
            return owed_status.size();
        endfunction

    endclass

endpackage

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue: drives pushes and pops
// over the input stream with random gaps and back-pressure, and checks every
// status word against a sorted software copy of the queue.
// ----------------------------------------------------------------------------
// A directed opening covers the empty pop, ties, a new minimum, priority and
// handle extremes, filling the queue, a push into the full queue and pops.
// The random part swings between push-heavy and pop-heavy phases so the queue
// runs full and empty many times; half of the pushed priorities come from a
// narrow range so ties are common. The output side stalls at random, once for
// a long stretch so the queue backs up into its input, and the input side
// pauses once until every status word has come back.
// ----------------------------------------------------------------------------

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;
    import queue_check_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int ITEM_TOTAL     = 800;
    localparam int IDLE_PCT       = 19;
    // Longest push visits every held slot; allow over twice its length
    localparam int SETTLE_CYCLES  = 2 * (QUEUE_DEPTH + 3) + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    // Output-side schedule, in cycles after the start of the run
    localparam int STEADY_FROM    = 1200;
    localparam int STEADY_TO      = 2400;
    localparam int HOLD_START     = 3000;
    localparam int HOLD_CYCLES    = 300;
    // Input-side schedule, in operations sent
    localparam int GAPLESS_FROM   = 150;
    localparam int GAPLESS_TO     = 300;
    localparam int PAUSE_AT       = 500;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] priority_req, [23:8] process_tag
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // [0] op (0 push, 1 pop)
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] head_priority, [23:8] head_tag, [24] is_empty,
    // [29:25] entry_count, [31:30] error_code
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    queue_scoreboard sb = new(QUEUE_DEPTH);

    int ops_sent = 0;
    bit gapless  = 1'b0;

    sorted_priority_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one operation from a falling edge and hold it until the transfer.
    // Afterwards, idle now and then with noise on the data lines. tvalid is
    // only lowered in such a gap or in the status drain, so a back-to-back
    // operation never drives it twice in one step.
    task automatic send_op(input logic op, input logic [PRIO_W-1:0] prio,
                           input logic [TAG_W-1:0] tag);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {tag, prio};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        ops_sent++;
        if (!gapless && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(6, 1);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_DATA_W'($urandom);
            s_axis_tuser  <= 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drop tvalid and wait at falling edges until every status word is back.
    task automatic wait_for_status_drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.outstanding() != 0);
    endtask

    // Input side: reset, directed opening, then random phases.
    initial begin
        int   push_pct;
        logic op;
        logic [PRIO_W-1:0] prio;

        push_pct = 50;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Pop of the empty queue; the data lines carry ignored content
        send_op(OP_POP, 8'hA5, 16'h5A5A);
        // Equal priorities keep arrival order, then a new minimum takes the head
        send_op(OP_PUSH, 8'h80, 16'h1111);
        send_op(OP_PUSH, 8'h80, 16'h2222);
        send_op(OP_PUSH, 8'h40, 16'h3333);
        // Field extremes, ties at both ends of the priority range
        send_op(OP_PUSH, 8'hFF, 16'hFFFF);
        send_op(OP_PUSH, 8'h00, 16'h0000);
        send_op(OP_PUSH, 8'h00, 16'h0001);
        send_op(OP_PUSH, 8'hFF, 16'h0002);
        // Fill the remaining slots
        for (int k = 0; k < QUEUE_DEPTH - 7; k++)
            send_op(OP_PUSH, 8'($urandom), 16'($urandom));
        // Push into the full queue: dropped and flagged
        send_op(OP_PUSH, 8'h10, 16'hBEEF);
        repeat (4) send_op(OP_POP, 8'($urandom), 16'($urandom));

        while (ops_sent < ITEM_TOTAL) begin
            // Swing the push share so the queue runs full and empty in turn
            if (ops_sent % 40 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 80;
                endcase
            end
            gapless = (ops_sent >= GAPLESS_FROM && ops_sent < GAPLESS_TO);
            if (ops_sent == PAUSE_AT)
                wait_for_status_drain();
            op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
            // Narrow range half the time to make ties common
            prio = $urandom_range(1) ? PRIO_W'($urandom_range(7)) : PRIO_W'($urandom);
            send_op(op, prio, TAG_W'($urandom));
        end

        wait_for_status_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Output side: random stalls, a steady stretch, and one long hold-off that
    // lets the queue back up until it stops taking operations.
    initial begin
        int cycle;
        cycle = 0;
        forever begin
            @(negedge i_clk);
            cycle++;
            if (cycle == HOLD_START) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                cycle += HOLD_CYCLES;
            end else if (cycle >= STEADY_FROM && cycle < STEADY_TO) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Sample both transfers at the rising edge; note the operation first.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_operation(s_axis_tuser, t_entry'(s_axis_tdata));
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_status(m_axis_tdata);
    end

    // Abort when neither side has moved a transfer for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
sim/queue_check_pkg.sv
sim/tb_top.sv
